FILE: hw/rtl/bmp_rle8_run_decoder_macros.svh
// Assertion helpers used by the datapath RTL.
`ifndef BMP_RLE8_RUN_DECODER_MACROS_SVH
`define BMP_RLE8_RUN_DECODER_MACROS_SVH

// Property must hold at every edge outside reset.
`define BRD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define BRD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/brd_pkg.sv
package brd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W = 13;
  localparam int CFG_RESET_SIZE = 256;

  typedef struct packed {
    logic load_byte;
    logic mul_height;
    logic restart;
    logic decode;
    logic run_seg;
    logic dy_sub;
  } brd_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic start_run;
    logic start_dy;
    logic run_last;
  } brd_status_t;

endpackage

FILE: hw/rtl/brd_ctrl.sv
module brd_ctrl import brd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_sof,
  output logic        in_ready,
  input  brd_status_t status,
  output brd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR_MUL,
    S_CLR_LOAD,
    S_DECODE,
    S_RUN,
    S_DY_SUB
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_next    = in_sof ? S_CLR_MUL : S_DECODE;
        end
      end
      S_CLR_MUL: begin
        cmd.mul_height = 1'b1;
        state_next     = S_CLR_LOAD;
      end
      S_CLR_LOAD: begin
        cmd.restart = 1'b1;
        state_next  = S_DECODE;
      end
      S_DECODE: begin
        if (!status.out_busy) begin
          cmd.decode = 1'b1;
          if (status.start_run) state_next = S_RUN;
          else if (status.start_dy) state_next = S_DY_SUB;
          else state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (!status.out_busy) begin
          cmd.run_seg = 1'b1;
          if (status.run_last) state_next = S_IDLE;
        end
      end
      S_DY_SUB: begin
        cmd.dy_sub = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

FILE: hw/rtl/brd_datapath.sv
`include "bmp_rle8_run_decoder_macros.svh"

module brd_datapath import brd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] image_width,
  input  logic [CFG_W-1:0] image_height,
  input  logic [7:0]       data_byte,
  input  brd_cmd_t         cmd,
  output brd_status_t      status,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [23:0]      out_address,
  output logic [7:0]       out_run_length,
  output logic [7:0]       out_color_index,
  output logic             out_last
);

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_VALUE = 3'd1,
    PH_DX    = 3'd2,
    PH_DY    = 3'd3,
    PH_LIT   = 3'd4,
    PH_PAD   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_RUN       = 2'd0;
  localparam logic [1:0] KIND_EOB       = 2'd1;
  localparam logic [1:0] KIND_EXHAUSTED = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  localparam int COL_MAX_I = 8191;
  localparam int MAXW_I    = (MAX_WIDTH  > COL_MAX_I) ? COL_MAX_I : MAX_WIDTH;
  localparam int MAXH_I    = (MAX_HEIGHT > COL_MAX_I) ? COL_MAX_I : MAX_HEIGHT;
  localparam int RST_W     = (CFG_RESET_SIZE > MAXW_I) ? MAXW_I : CFG_RESET_SIZE;
  localparam int RST_H     = (CFG_RESET_SIZE > MAXH_I) ? MAXH_I : CFG_RESET_SIZE;
  localparam int ROW_NEED  = $clog2(longint'(MAXW_I) * longint'(MAXH_I)) + 1;
  localparam int ROW_W     = (ROW_NEED > 25) ? ROW_NEED : 25;
  localparam int RESET_OFFSET = RST_W * (RST_H - 1);

  localparam logic [CFG_W-1:0] MAXW_V  = CFG_W'(MAXW_I);
  localparam logic [CFG_W-1:0] MAXH_V  = CFG_W'(MAXH_I);
  localparam logic [CFG_W-1:0] MINW_V  = CFG_W'(8);
  localparam logic [CFG_W-1:0] COL_MAX = CFG_W'(COL_MAX_I);

  phase_t             phase;
  logic [7:0]         byte_q;
  logic [7:0]         count_hold;
  logic [7:0]         literal_left;
  logic               pad_pending;
  logic [ROW_W-1:0]   row_offset;
  logic [CFG_W-1:0]   column;
  logic               wrapped_last;
  logic               finished;
  logic [7:0]         run_left;
  logic [7:0]         run_color;
  logic [2*CFG_W-1:0] prod;

  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [CFG_W-1:0] mul_op;
  logic [CFG_W-1:0] room;
  logic [7:0]       seg;
  logic [CFG_W:0]   col_sum;
  logic [CFG_W:0]   col_dx;
  logic             wraps;
  logic             row_neg;
  logic [23:0]      seg_addr;
  logic [7:0]       lit_next;
  logic             out_busy;
  logic             emit;
  logic [ROW_W-1:0] w_ext;

  assign eff_w = (image_width < MINW_V) ? MINW_V :
                 (image_width > MAXW_V) ? MAXW_V : image_width;
  assign eff_h = (image_height == '0) ? CFG_W'(1) :
                 (image_height > MAXH_V) ? MAXH_V : image_height;
  assign w_ext = ROW_W'(eff_w);

  assign mul_op = cmd.mul_height ? (eff_h - CFG_W'(1)) : CFG_W'(byte_q);

  assign row_neg  = row_offset[ROW_W-1];
  assign room     = eff_w - column;
  assign seg      = (column < eff_w) ?
                    ((CFG_W'(run_left) < room) ? run_left : room[7:0]) : 8'd1;
  assign col_sum  = {1'b0, column} + (CFG_W+1)'(seg);
  assign wraps    = col_sum >= {1'b0, eff_w};
  assign seg_addr = row_offset[23:0] + 24'(column);
  assign col_dx   = {1'b0, column} + (CFG_W+1)'(byte_q);
  assign lit_next = (literal_left != 8'd0) ? literal_left - 8'd1 : 8'd0;

  assign out_busy = out_valid && !out_ready;

  assign status.out_busy  = out_busy;
  assign status.start_run = !finished && !row_neg &&
                            ((phase == PH_VALUE && count_hold != 8'd0) || phase == PH_LIT);
  assign status.start_dy  = !finished && !row_neg && (phase == PH_DY);
  assign status.run_last  = row_neg || (seg == run_left);

  assign emit = cmd.run_seg ||
                (cmd.decode && !finished &&
                 (row_neg || (phase == PH_VALUE && count_hold == 8'd0 &&
                              byte_q == ESC_EOB)));

  always_ff @(posedge clk) begin
    prod <= (2*CFG_W)'(eff_w) * (2*CFG_W)'(mul_op);
    if (cmd.load_byte) byte_q <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      count_hold   <= '0;
      literal_left <= '0;
      pad_pending  <= 1'b0;
      row_offset   <= ROW_W'(RESET_OFFSET);
      column       <= '0;
      wrapped_last <= 1'b0;
      finished     <= 1'b0;
      run_left     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cmd.restart) begin
        phase        <= PH_COUNT;
        count_hold   <= '0;
        literal_left <= '0;
        pad_pending  <= 1'b0;
        row_offset   <= ROW_W'(prod);
        column       <= '0;
        wrapped_last <= 1'b0;
        finished     <= 1'b0;
      end

      if (cmd.dy_sub) row_offset <= row_offset - ROW_W'(prod);

      if (cmd.decode && !finished) begin
        if (row_neg) begin
          finished        <= 1'b1;
          out_kind        <= KIND_EXHAUSTED;
          out_address     <= '0;
          out_run_length  <= '0;
          out_color_index <= '0;
          out_last        <= 1'b1;
        end else begin
          unique case (phase)
            PH_VALUE: begin
              phase <= PH_COUNT;
              if (count_hold != 8'd0) begin
                run_left  <= count_hold;
                run_color <= byte_q;
              end else if (byte_q == ESC_EOL) begin
                if (!wrapped_last) begin
                  column     <= '0;
                  row_offset <= row_offset - w_ext;
                end
              end else if (byte_q == ESC_EOB) begin
                finished        <= 1'b1;
                out_kind        <= KIND_EOB;
                out_address     <= '0;
                out_run_length  <= '0;
                out_color_index <= '0;
                out_last        <= 1'b1;
              end else if (byte_q == ESC_DELTA) begin
                phase <= PH_DX;
              end else begin
                literal_left <= byte_q;
                pad_pending  <= byte_q[0];
                phase        <= PH_LIT;
              end
            end
            PH_DX: begin
              column <= col_dx[CFG_W] ? COL_MAX : col_dx[CFG_W-1:0];
              phase  <= PH_DY;
            end
            PH_DY: phase <= PH_COUNT;
            PH_LIT: begin
              run_left     <= 8'd1;
              run_color    <= byte_q;
              literal_left <= lit_next;
              if (lit_next == 8'd0) begin
                phase       <= pad_pending ? PH_PAD : PH_COUNT;
                pad_pending <= 1'b0;
              end
            end
            PH_PAD: phase <= PH_COUNT;
            default: begin
              count_hold <= byte_q;
              phase      <= PH_VALUE;
            end
          endcase
        end
      end

      if (cmd.run_seg) begin
        if (row_neg) begin
          finished        <= 1'b1;
          run_left        <= '0;
          out_kind        <= KIND_EXHAUSTED;
          out_address     <= '0;
          out_run_length  <= '0;
          out_color_index <= '0;
          out_last        <= 1'b1;
        end else begin
          run_left        <= run_left - seg;
          out_kind        <= KIND_RUN;
          out_address     <= seg_addr;
          out_run_length  <= seg;
          out_color_index <= run_color;
          out_last        <= (seg == run_left);
          if (wraps) begin
            column       <= '0;
            row_offset   <= row_offset - w_ext;
            wrapped_last <= 1'b1;
          end else begin
            column       <= col_sum[CFG_W-1:0];
            wrapped_last <= 1'b0;
          end
        end
      end
    end
  end

  `BRD_ASSERT_NEVER(a_no_overwrite, clk, rst, emit && out_busy, "result overwritten while stalled")
  `BRD_ASSERT_NEVER(a_run_nonempty, clk, rst, cmd.run_seg && run_left == 8'd0, "segment with no pixels left")
  `BRD_ASSERT(a_marker_last, clk, rst, out_valid && out_kind != KIND_RUN |-> out_last, "marker without last")
  `BRD_ASSERT(a_seg_len, clk, rst, out_valid && out_kind == KIND_RUN |-> out_run_length != 8'd0, "empty run beat")

endmodule

FILE: hw/rtl/bmp_rle8_run_decoder.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte; tuser: start_of_image
// m_*       out  m_tvalid/m_tready  tdata: address, run_length, color_index;
//                                   tuser: kind; tlast: last
// apb       in   psel/penable       image_width @0x0, image_height @0x4
//
// A byte has an accept beat, then a decode step.
// start_of_image adds a size multiply and a state load; a delta adds a row subtract on its dy byte.
// Each run segment takes its own S_RUN step; a run splits at every row end (up to 33 beats per byte).
// The output register lets the decoder finish a byte while m_tready is low; the next byte
// is still accepted, but its decode step or the next segment waits for that beat.
// rst is synchronous and restores 256x256 with no clearing pass.
module bmp_rle8_run_decoder import brd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_image
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [23:0] address, [31:24] run_length, [39:32] color_index
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             cfg_write;

  brd_cmd_t    cmd;
  brd_status_t status;

  logic [23:0] out_address;
  logic [7:0]  out_run_length;
  logic [7:0]  out_color_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(CFG_RESET_SIZE);
      image_height <= CFG_W'(CFG_RESET_SIZE);
    end else if (cfg_write) begin
      if (paddr[2] == REG_IMAGE_WIDTH) image_width <= pwdata[CFG_W-1:0];
      else image_height <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(image_height) : 32'(image_width);

  brd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_sof   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .image_width     (image_width),
    .image_height    (image_height),
    .data_byte       (s_tdata),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_kind        (m_tuser),
    .out_address     (out_address),
    .out_run_length  (out_run_length),
    .out_color_index (out_color_index),
    .out_last        (m_tlast)
  );

  assign m_tdata = {out_color_index, out_run_length, out_address};

endmodule
